// ===== sv/msf_pkg.sv =====
`default_nettype none

package msf_pkg;

    // Fixed-point format and derived datapath widths
    localparam int FRAC_BITS  = 16;
    localparam int DW         = 32;                     // data word
    localparam int CSW        = 16;                     // cell size / roughness width
    localparam int SQW        = 2 * DW;                 // sum of squared velocities
    localparam int RSTEPS     = DW;                     // square root and bed quotient bits
    localparam int CBW        = DW + 2 * FRAC_BITS;     // cube root radicand
    localparam int CRW        = (CBW + 2) / 3;          // cube root bits and steps
    localparam int PW         = DW + CRW - FRAC_BITS;   // depth to the four-thirds
    localparam int GW         = 2 * DW - 2 * FRAC_BITS; // n squared times speed
    localparam int NW         = DW + GW;                // friction numerator
    localparam int QW         = DW + 1;                 // friction quotient, saturates at 2^DW
    localparam int CMPW       = ((NW > PW + QW) ? NW : PW + QW) + 1;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef enum logic [1:0] {
        CFG_MANNING_N    = 2'd0,
        CFG_DEPTH_OFFSET = 2'd1,
        CFG_CELL_SIZE    = 2'd2,
        CFG_DRY_DEPTH    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] manning_n;
        logic [20:0] depth_offset;
        logic [15:0] cell_size;
        logic [20:0] dry_depth;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        manning_n:    16'd1966,
        depth_offset: 21'd0,
        cell_size:    16'd1,
        dry_depth:    21'd65536
    };

    typedef struct packed {
        logic [30:0]        depth;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] elev_diff_x;
        logic signed [31:0] elev_diff_y;
        logic               last_cell;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] bed_slope_x;
        logic signed [31:0] bed_slope_y;
        logic signed [31:0] friction_x;
        logic signed [31:0] friction_y;
        logic               last_out;
    } out_item_t;

    // Classified cell as it sits in the queue
    typedef struct packed {
        logic          last;
        logic          dry;
        logic          neg_vx;
        logic          neg_vy;
        logic          neg_ex;
        logic          neg_ey;
        logic [DW-1:0] mag_vx;
        logic [DW-1:0] mag_vy;
        logic [DW-1:0] mag_ex;
        logic [DW-1:0] mag_ey;
        logic [DW-1:0] d_sum;
    } fe_t;

endpackage

`default_nettype wire

// ===== sv/msf_front.sv =====
`default_nettype none

module msf_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire msf_pkg::cfg_t    cfg,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire msf_pkg::in_item_t in_data,
    output logic                  push_valid,
    input  wire logic             push_ready,
    output msf_pkg::fe_t          push_data
);

    localparam int DW = msf_pkg::DW;

    logic         fr_valid_reg;
    logic         fr_valid_next;
    msf_pkg::fe_t fr_data_reg;
    msf_pkg::fe_t fr_data_next;

    function automatic logic [DW-1:0] magnitude(input logic [DW-1:0] x);
        return x[DW-1] ? (DW'(0) - x) : x;
    endfunction

    assign in_ready   = !fr_valid_reg || push_ready;
    assign push_valid = fr_valid_reg;
    assign push_data  = fr_data_reg;

    always_comb
    begin
        fr_valid_next = fr_valid_reg;
        fr_data_next  = fr_data_reg;
        if (in_ready)
        begin
            fr_valid_next = in_valid;
        end
        if (in_valid && in_ready)
        begin
            // split signs from magnitudes, mark dry cells, form the shifted depth
            fr_data_next.last   = in_data.last_cell;
            fr_data_next.dry    = DW'(in_data.depth) < DW'(cfg.dry_depth);
            fr_data_next.neg_vx = in_data.vel_x[DW-1];
            fr_data_next.neg_vy = in_data.vel_y[DW-1];
            fr_data_next.neg_ex = in_data.elev_diff_x[DW-1];
            fr_data_next.neg_ey = in_data.elev_diff_y[DW-1];
            fr_data_next.mag_vx = magnitude(in_data.vel_x);
            fr_data_next.mag_vy = magnitude(in_data.vel_y);
            fr_data_next.mag_ex = magnitude(in_data.elev_diff_x);
            fr_data_next.mag_ey = magnitude(in_data.elev_diff_y);
            fr_data_next.d_sum  = DW'(in_data.depth) + DW'(cfg.depth_offset);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fr_data_reg <= fr_data_next;
    end

endmodule

`default_nettype wire

// ===== sv/msf_fifo.sv =====
`default_nettype none

module msf_fifo (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push_valid,
    output logic              push_ready,
    input  wire msf_pkg::fe_t push_data,
    output logic              pop_valid,
    input  wire logic         pop_ready,
    output msf_pkg::fe_t      pop_data
);

    localparam int AW = msf_pkg::FIFO_AW;
    localparam int CW = AW + 1;

    msf_pkg::fe_t    mem_reg [msf_pkg::FIFO_DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            push_fire;
    logic            pop_fire;

    assign push_ready = count_reg != CW'(msf_pkg::FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg + CW'(push_fire) - CW'(pop_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/msf_back.sv =====
`default_nettype none

module msf_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire msf_pkg::cfg_t cfg,
    input  wire logic          pop_valid,
    output logic               pop_ready,
    input  wire msf_pkg::fe_t  pop_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output msf_pkg::out_item_t out_data
);

    localparam int F      = msf_pkg::FRAC_BITS;
    localparam int DW     = msf_pkg::DW;
    localparam int CSW    = msf_pkg::CSW;
    localparam int SQW    = msf_pkg::SQW;
    localparam int RSTEPS = msf_pkg::RSTEPS;
    localparam int CBW    = msf_pkg::CBW;
    localparam int CRW    = msf_pkg::CRW;
    localparam int PW     = msf_pkg::PW;
    localparam int GW     = msf_pkg::GW;
    localparam int NW     = msf_pkg::NW;
    localparam int QW     = msf_pkg::QW;
    localparam int CMPW   = msf_pkg::CMPW;
    localparam int BDW    = DW + CSW;
    localparam int NST    = RSTEPS + QW + 5;

    localparam logic [QW-1:0] NEG_LIM = QW'(1) << (DW - 1);
    localparam logic [QW-1:0] POS_LIM = NEG_LIM - QW'(1);
    localparam logic [QW-1:0] SAT_MAG = QW'(1) << DW;

    typedef struct packed {
        msf_pkg::fe_t     item;
        logic [SQW-1:0]   sq_rem;
        logic [DW-1:0]    sq_root;
        logic [CBW-1:0]   cb_rem;
        logic [CRW-1:0]   cb_root;
        logic [2*CRW-1:0] cb_sq;
        logic [DW-1:0]    bx_rem;
        logic [DW-1:0]    by_rem;
        logic [DW-1:0]    bx_quo;
        logic [DW-1:0]    by_quo;
    } rt_t;

    typedef struct packed {
        msf_pkg::fe_t  item;
        logic [DW-1:0] bed_x;
        logic [DW-1:0] bed_y;
        logic [PW-1:0] p;
        logic          sat_x;
        logic          sat_y;
        logic [NW-1:0] rem_x;
        logic [NW-1:0] rem_y;
        logic [QW-1:0] q_x;
        logic [QW-1:0] q_y;
    } dv_t;

    function automatic logic [DW-1:0] sat_word(input logic [QW-1:0] mag, input logic neg);
        logic [QW-1:0] lim;
        logic [QW-1:0] m;
        lim = neg ? NEG_LIM : POS_LIM;
        m   = (mag > lim) ? lim : mag;
        return neg ? (DW'(0) - m[DW-1:0]) : m[DW-1:0];
    endfunction

    logic               adv;
    logic [NST-1:0]     vld_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    msf_pkg::out_item_t out_data_reg;
    msf_pkg::out_item_t out_data_next;
    logic [CSW-1:0]     cs_eff;
    logic [DW-1:0]      nsq_reg;

    msf_pkg::fe_t   p0_item_reg;
    logic [SQW-1:0] p0_sqx_reg;
    logic [SQW-1:0] p0_sqy_reg;

    rt_t rt_reg  [0:RSTEPS];
    rt_t rt_next [0:RSTEPS];

    msf_pkg::fe_t   m0_item_reg;
    logic [DW-1:0]  m0_bx_reg;
    logic [DW-1:0]  m0_by_reg;
    logic [GW-1:0]  m0_g_reg;
    logic [PW-1:0]  m0_p_reg;
    logic [GW-1:0]  m0_g_next;
    logic [PW-1:0]  m0_p_next;
    logic [2*DW-1:0]    g_prod;
    logic [DW+CRW-1:0]  p_prod;

    msf_pkg::fe_t   m1_item_reg;
    logic [DW-1:0]  m1_bx_reg;
    logic [DW-1:0]  m1_by_reg;
    logic [PW-1:0]  m1_p_reg;
    logic [NW-1:0]  m1_nx_reg;
    logic [NW-1:0]  m1_ny_reg;

    dv_t dv_reg  [0:QW];
    dv_t dv_next [0:QW];

    // the whole column moves together whenever the output register frees up
    assign adv       = !out_valid_reg || out_ready;
    assign pop_ready = adv;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cs_eff    = (cfg.cell_size == '0) ? CSW'(1) : cfg.cell_size;

    always_ff @(posedge clk)
    begin
        nsq_reg <= DW'(cfg.manning_n) * DW'(cfg.manning_n);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                vld_reg <= {vld_reg[NST-2:0], pop_valid};
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid_next = adv ? vld_reg[NST-1] : out_valid_reg;

    // squares of the velocity magnitudes
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0_item_reg <= pop_data;
            p0_sqx_reg  <= pop_data.mag_vx * pop_data.mag_vx;
            p0_sqy_reg  <= pop_data.mag_vy * pop_data.mag_vy;
        end
    end

    // load the root column
    always_comb
    begin
        rt_next[0]         = '0;
        rt_next[0].item    = p0_item_reg;
        rt_next[0].sq_rem  = p0_sqx_reg + p0_sqy_reg;
        rt_next[0].cb_rem  = CBW'(p0_item_reg.d_sum) << (2 * F);
        rt_next[0].bx_rem  = p0_item_reg.mag_ex;
        rt_next[0].by_rem  = p0_item_reg.mag_ey;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rt_reg[0] <= rt_next[0];
        end
    end

    // per stage a square root bit, both bed quotient bits, a cube root bit for k < CRW
    for (genvar k = 0; k < RSTEPS; k++)
    begin : g_root
        localparam int B  = RSTEPS - 1 - k;
        localparam int CS = (k < CRW) ? 3 * (CRW - 1 - k) : 0;

        always_comb
        begin : blk_step
            rt_t            st;
            logic [SQW:0]   sq_cand;
            logic [BDW-1:0] bx_cand;
            logic [CBW-1:0] cb_try;
            st      = rt_reg[k];
            sq_cand = ((SQW+1)'(st.sq_root) << (B + 1)) | ((SQW+1)'(1) << (2 * B));
            if ((SQW+1)'(st.sq_rem) >= sq_cand)
            begin
                st.sq_rem     = st.sq_rem - sq_cand[SQW-1:0];
                st.sq_root[B] = 1'b1;
            end
            bx_cand = BDW'(cs_eff) << B;
            if (BDW'(st.bx_rem) >= bx_cand)
            begin
                st.bx_rem    = st.bx_rem - bx_cand[DW-1:0];
                st.bx_quo[B] = 1'b1;
            end
            if (BDW'(st.by_rem) >= bx_cand)
            begin
                st.by_rem    = st.by_rem - bx_cand[DW-1:0];
                st.by_quo[B] = 1'b1;
            end
            cb_try = '0;
            if (k < CRW)
            begin
                // trial term 3*(y^2 + y) + 1 for the doubled root y
                st.cb_root = st.cb_root << 1;
                st.cb_sq   = st.cb_sq << 2;
                cb_try     = ((CBW'(st.cb_sq) + CBW'(st.cb_root)) << 1)
                             + CBW'(st.cb_sq) + CBW'(st.cb_root) + CBW'(1);
                if ((st.cb_rem >> CS) >= cb_try)
                begin
                    st.cb_rem     = st.cb_rem - (cb_try << CS);
                    st.cb_sq      = st.cb_sq + (2*CRW)'({st.cb_root, 1'b0}) + (2*CRW)'(1);
                    st.cb_root[0] = 1'b1;
                end
            end
            rt_next[k+1] = st;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rt_reg[k+1] <= rt_next[k+1];
            end
        end
    end

    // n^2 * speed and depth^(4/3)
    always_comb
    begin
        g_prod    = nsq_reg * rt_reg[RSTEPS].sq_root;
        p_prod    = rt_reg[RSTEPS].item.d_sum * rt_reg[RSTEPS].cb_root;
        m0_g_next = g_prod[2*DW-1:2*F];
        m0_p_next = p_prod[DW+CRW-1:F];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m0_item_reg <= rt_reg[RSTEPS].item;
            m0_bx_reg   <= sat_word(QW'(rt_reg[RSTEPS].bx_quo), rt_reg[RSTEPS].item.neg_ex);
            m0_by_reg   <= sat_word(QW'(rt_reg[RSTEPS].by_quo), rt_reg[RSTEPS].item.neg_ey);
            m0_g_reg    <= m0_g_next;
            m0_p_reg    <= m0_p_next;
        end
    end

    // numerators |v| * G
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_item_reg <= m0_item_reg;
            m1_bx_reg   <= m0_bx_reg;
            m1_by_reg   <= m0_by_reg;
            m1_p_reg    <= m0_p_reg;
            m1_nx_reg   <= NW'(m0_item_reg.mag_vx) * NW'(m0_g_reg);
            m1_ny_reg   <= NW'(m0_item_reg.mag_vy) * NW'(m0_g_reg);
        end
    end

    // flag quotients that cannot fit, then start the division column
    always_comb
    begin
        dv_next[0]       = '0;
        dv_next[0].item  = m1_item_reg;
        dv_next[0].bed_x = m1_bx_reg;
        dv_next[0].bed_y = m1_by_reg;
        dv_next[0].p     = m1_p_reg;
        dv_next[0].rem_x = m1_nx_reg;
        dv_next[0].rem_y = m1_ny_reg;
        dv_next[0].sat_x = (m1_nx_reg != '0)
                           && (CMPW'(m1_nx_reg) >= (CMPW'(m1_p_reg) << QW));
        dv_next[0].sat_y = (m1_ny_reg != '0)
                           && (CMPW'(m1_ny_reg) >= (CMPW'(m1_p_reg) << QW));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_reg[0] <= dv_next[0];
        end
    end

    // a zero divisor leaves the quotient at zero: a zero numerator then gives zero
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        localparam int B = QW - 1 - k;

        always_comb
        begin : blk_step
            dv_t             st;
            logic [CMPW-1:0] cand;
            st   = dv_reg[k];
            cand = CMPW'(st.p) << B;
            if ((st.p != '0) && (CMPW'(st.rem_x) >= cand))
            begin
                st.rem_x  = st.rem_x - cand[NW-1:0];
                st.q_x[B] = 1'b1;
            end
            if ((st.p != '0) && (CMPW'(st.rem_y) >= cand))
            begin
                st.rem_y  = st.rem_y - cand[NW-1:0];
                st.q_y[B] = 1'b1;
            end
            dv_next[k+1] = st;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[k+1] <= dv_next[k+1];
            end
        end
    end

    // sign, saturate, zero dry cells
    always_comb
    begin
        out_data_next.bed_slope_x = dv_reg[QW].bed_x;
        out_data_next.bed_slope_y = dv_reg[QW].bed_y;
        out_data_next.friction_x  = dv_reg[QW].item.dry ? '0 :
            sat_word(dv_reg[QW].sat_x ? SAT_MAG : dv_reg[QW].q_x, dv_reg[QW].item.neg_vx);
        out_data_next.friction_y  = dv_reg[QW].item.dry ? '0 :
            sat_word(dv_reg[QW].sat_y ? SAT_MAG : dv_reg[QW].q_y, dv_reg[QW].item.neg_vy);
        out_data_next.last_out    = dv_reg[QW].item.last;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/manning_friction_slope.sv =====
// Channel   Direction  Handshake            Payload
// in        to block   in_valid/in_ready    in_data   (in_item_t: one grid cell)
// out       from block out_valid/out_ready  out_data  (out_item_t: slopes of that cell)
// cfg       to block   cfg_valid/cfg_ready  cfg_index, cfg_data (register write)
//
// One cell per clock sustained while out_ready holds; a result passes in order the
// front register, queue, squares, root load, 32-stage square root column, two product
// stages, division load, the 33-stage quotient column and the output register.
// Reset clears every valid flag, the queue pointers and the registers to their defaults.
// A stalled output holds the whole back column; the queue and front register take up to
// five more transfers, by how full the queue was, before in_ready falls.
// cfg_ready is always high; writes are registered, and manning_n is squared into nsq_reg.

`default_nettype none

module manning_friction_slope (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire msf_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output msf_pkg::out_item_t      out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire msf_pkg::cfg_idx_t  cfg_index,
    input  wire logic [31:0]        cfg_data
);

    msf_pkg::cfg_t cfg_reg;
    logic          push_valid;
    logic          push_ready;
    msf_pkg::fe_t  push_data;
    logic          pop_valid;
    logic          pop_ready;
    msf_pkg::fe_t  pop_data;

    assign cfg_ready = 1'b1;

    // register file: keep only the bits each register defines
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= msf_pkg::CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                msf_pkg::CFG_MANNING_N:    cfg_reg.manning_n    <= cfg_data[15:0];
                msf_pkg::CFG_DEPTH_OFFSET: cfg_reg.depth_offset <= cfg_data[20:0];
                msf_pkg::CFG_CELL_SIZE:    cfg_reg.cell_size    <= cfg_data[15:0];
                msf_pkg::CFG_DRY_DEPTH:    cfg_reg.dry_depth    <= cfg_data[20:0];
                default:                   cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // front: take the transfer, split signs, flag dry cells
    msf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // short queue so the front keeps accepting while the back stalls
    msf_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // back: roots, products, quotients, saturation, output register
    msf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== sv/msf_checker.sv =====
`default_nettype none

module msf_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire msf_pkg::in_item_t  in_data,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire msf_pkg::out_item_t out_data,
    input wire logic               cfg_valid,
    input wire logic               cfg_ready,
    input wire msf_pkg::cfg_idx_t  cfg_index,
    input wire logic [31:0]        cfg_data
);

    // a result held back by the sink stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    // the register port never back-pressures
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("register write stalled");

    // nothing comes out straight after reset
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result presented on leaving reset");

endmodule

bind manning_friction_slope msf_checker u_msf_checker (.*);

`default_nettype wire
